### hdl/sac_pkg.sv
`timescale 1ns / 1ps
package sac_pkg;

	localparam int ADDR_W     = 32;
	localparam int DATA_W     = 32;
	localparam int SIZE_W     = 3;
	localparam int SEED_W     = 16;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 72;
	localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_REFILL = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_FETCH = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_SECOND = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_TAG,
		ST_WR_CMP,
		ST_WR_DONE,
		ST_RD_TAG,
		ST_RD_CMP,
		ST_FETCH,
		ST_G_RD,
		ST_G_TAKE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  data;
		logic [SIZE_W-1:0]  size;
		logic               hit;
	} res_t;

endpackage

### hdl/set_assoc_write_through_cache_unit.sv
`timescale 1ns / 1ps
// Write-through, no-write-allocate data cache: WAYS ways x SETS sets of LINE_BYTES-byte
// lines, tags (each with its valid bit) and data in two synchronous RAMs. After reset
// the tag RAM is cleared one set per cycle, so s_axis_tready stays low until every
// set is cleared. One beat is taken at a time; the input is ready again once the
// previous access has walked through. A write of n bytes does a tag read and a
// compare, with a byte write on a hit, for each byte, then posts the write-through.
// A read hit does a tag lookup, reads and takes each byte through the data RAM one
// at a time, then posts the data, with a second tag lookup when the read crosses into
// the next line. A miss posts a line fetch and then takes LINE_BYTES/4 refill beats
// at one per cycle before the bytes are gathered; a read crossing a line goes through
// this for each line that misses. Other accesses during a pending fill are dropped.
// Results sit in an output register, so the next beat may be taken while a result
// still waits on m_axis_tready.
module set_assoc_write_through_cache_unit #(
	parameter int WAYS       = 8,
	parameter int SETS       = 128,
	parameter int LINE_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// addr[31:0], size_bytes[34:32], data[66:35], zero pad
	input  logic [sac_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_addr[31:0], out_data[63:32], out_size[66:64], hit[67], zero pad
	output logic [sac_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// kind[1:0]
	output logic [1:0]                        m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sac_pkg::SEED_W-1:0]        cfg_data
);
	import sac_pkg::*;

	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = $clog2(SETS);
	localparam int TAG_W = ADDR_W - OFF_W - SET_W;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WRD_W = OFF_W - 2;
	localparam int DA_W  = SET_W + WAY_W + WRD_W;

	logic                      res_valid;
	logic                      res_ready;
	res_t                      res;
	res_t                      out_q;
	logic                      out_valid_q;
	logic [SET_W-1:0]          tr_rd_set;
	logic [WAYS*(TAG_W+1)-1:0] tr_rd_row;
	logic                      tr_clr;
	logic                      tr_we;
	logic [SET_W-1:0]          tr_wr_set;
	logic [WAY_W-1:0]          tr_wr_way;
	logic [TAG_W-1:0]          tr_wr_tag;
	logic [DA_W-1:0]           dr_addr;
	logic                      dr_we;
	logic [3:0]                dr_be;
	logic [31:0]               dr_wdata;
	logic [31:0]               dr_rdata;

	// seed writes land straight in the LFSR
	assign cfg_ready = 1'b1;

	sac_ctrl #(
		.WAYS(WAYS), .SETS(SETS), .LINE_BYTES(LINE_BYTES), .OFF_W(OFF_W),
		.SET_W(SET_W), .TAG_W(TAG_W), .WAY_W(WAY_W), .WRD_W(WRD_W), .DA_W(DA_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_addr   (s_axis_tdata[31:0]),
		.in_size   (s_axis_tdata[34:32]),
		.in_data   (s_axis_tdata[66:35]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_seed  (cfg_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.tr_rd_set (tr_rd_set),
		.tr_rd_row (tr_rd_row),
		.tr_clr    (tr_clr),
		.tr_we     (tr_we),
		.tr_wr_set (tr_wr_set),
		.tr_wr_way (tr_wr_way),
		.tr_wr_tag (tr_wr_tag),
		.dr_addr   (dr_addr),
		.dr_we     (dr_we),
		.dr_be     (dr_be),
		.dr_wdata  (dr_wdata),
		.dr_rdata  (dr_rdata)
	);

	sac_tag_ram #(
		.WAYS(WAYS), .SETS(SETS), .TAG_W(TAG_W), .SET_W(SET_W), .WAY_W(WAY_W)
	) u_tag_ram (
		.clk    (clk),
		.rd_set (tr_rd_set),
		.rd_row (tr_rd_row),
		.clr    (tr_clr),
		.we     (tr_we),
		.wr_set (tr_wr_set),
		.wr_way (tr_wr_way),
		.wr_tag (tr_wr_tag)
	);

	sac_data_ram #(
		.DA_W(DA_W)
	) u_data_ram (
		.clk   (clk),
		.addr  (dr_addr),
		.we    (dr_we),
		.be    (dr_be),
		.wdata (dr_wdata),
		.rdata (dr_rdata)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {4'd0, out_q.hit, out_q.size, out_q.data, out_q.addr};

endmodule

### hdl/sac_tag_ram.sv
`timescale 1ns / 1ps
module sac_tag_ram #(
	parameter int WAYS  = 8,
	parameter int SETS  = 128,
	parameter int TAG_W = 19,
	parameter int SET_W = 7,
	parameter int WAY_W = 3
) (
	input  logic                      clk,
	input  logic [SET_W-1:0]          rd_set,
	output logic [WAYS*(TAG_W+1)-1:0] rd_row,
	input  logic                      clr,
	input  logic                      we,
	input  logic [SET_W-1:0]          wr_set,
	input  logic [WAY_W-1:0]          wr_way,
	input  logic [TAG_W-1:0]          wr_tag
);

	localparam int ENT_W = TAG_W + 1;

	// one row per set, all ways side by side, each way {valid, tag}
	logic [WAYS*ENT_W-1:0] mem [SETS];

	always_ff @(posedge clk) begin
		if (clr) begin
			mem[wr_set] <= '0;
		end else if (we) begin
			mem[wr_set][wr_way*ENT_W +: ENT_W] <= {1'b1, wr_tag};
		end
		rd_row <= mem[rd_set];
	end

endmodule

### hdl/sac_data_ram.sv
`timescale 1ns / 1ps
module sac_data_ram #(
	parameter int DA_W = 14
) (
	input  logic            clk,
	input  logic [DA_W-1:0] addr,
	input  logic            we,
	input  logic [3:0]      be,
	input  logic [31:0]     wdata,
	output logic [31:0]     rdata
);

	logic [31:0] mem [1 << DA_W];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (we && be[k]) begin
				mem[addr][8*k +: 8] <= wdata[8*k +: 8];
			end
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/sac_ctrl.sv
`timescale 1ns / 1ps
module sac_ctrl #(
	parameter int WAYS       = 8,
	parameter int SETS       = 128,
	parameter int LINE_BYTES = 64,
	parameter int OFF_W      = 6,
	parameter int SET_W      = 7,
	parameter int TAG_W      = 19,
	parameter int WAY_W      = 3,
	parameter int WRD_W      = 4,
	parameter int DA_W       = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sac_pkg::op_t              in_op,
	input  logic [31:0]               in_addr,
	input  logic [2:0]                in_size,
	input  logic [31:0]               in_data,
	input  logic                      cfg_we,
	input  logic [15:0]               cfg_seed,
	output logic                      res_valid,
	input  logic                      res_ready,
	output sac_pkg::res_t             res,
	output logic [SET_W-1:0]          tr_rd_set,
	input  logic [WAYS*(TAG_W+1)-1:0] tr_rd_row,
	output logic                      tr_clr,
	output logic                      tr_we,
	output logic [SET_W-1:0]          tr_wr_set,
	output logic [WAY_W-1:0]          tr_wr_way,
	output logic [TAG_W-1:0]          tr_wr_tag,
	output logic [DA_W-1:0]           dr_addr,
	output logic                      dr_we,
	output logic [3:0]                dr_be,
	output logic [31:0]               dr_wdata,
	input  logic [31:0]               dr_rdata
);
	import sac_pkg::*;

	localparam int WPL   = LINE_BYTES / 4;
	localparam int ENT_W = TAG_W + 1;

	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [SET_W-1:0]  clr_q;
	logic [15:0]       lfsr_q;
	logic [WRD_W-1:0]  beat_q;
	logic [WAY_W-1:0]  fill_way_q;
	logic              all_hit_q;
	logic [31:0]       p_addr_q;
	logic [2:0]        p_size_q;
	logic [31:0]       pd_q;
	logic [31:0]       la_q;
	logic [31:0]       acc_q;
	logic [2:0]        n1_q;
	logic [2:0]        gn_q;
	logic [1:0]        gpos_q;
	logic [WAY_W-1:0]  gw_q;
	logic              part_q;

	logic [2:0]        sz;
	logic [OFF_W:0]    room;
	logic [2:0]        n1_in;
	logic [2:0]        n2;
	logic [SET_W-1:0]  la_set;
	logic [TAG_W-1:0]  la_tag;
	logic [WAYS-1:0]   vrow;
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic              inv_found;
	logic [WAY_W-1:0]  inv_way;
	logic [15:0]       lfsr_next;
	logic              refill_last;
	logic [7:0]        rd_byte;
	logic [31:0]       wt_data;

	always_comb begin
		case (in_size)
			3'd0:    sz = 3'd1;
			3'd1,
			3'd2,
			3'd3,
			3'd4:    sz = in_size;
			default: sz = 3'd4;
		endcase
	end

	assign room   = (OFF_W+1)'(LINE_BYTES) - {1'b0, in_addr[OFF_W-1:0]};
	assign n1_in  = ((OFF_W+1)'(sz) < room) ? sz : room[2:0];
	assign n2     = p_size_q - n1_q;
	assign la_set = la_q[OFF_W +: SET_W];
	assign la_tag = la_q[31 -: TAG_W];
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
	assign refill_last = (beat_q == WRD_W'(WPL - 1));
	assign rd_byte = dr_rdata[8*la_q[1:0] +: 8];

	// valid bit sits on top of each way's tag
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			vrow[w] = tr_rd_row[w*ENT_W + TAG_W];
		end
	end

	// tag match and first free way
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && vrow[w] && tr_rd_row[w*ENT_W +: TAG_W] == la_tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!inv_found && !vrow[w]) begin
				inv_found = 1'b1;
				inv_way   = WAY_W'(w);
			end
		end
	end

	always_comb begin
		case (p_size_q)
			3'd1:    wt_data = {24'd0, pd_q[7:0]};
			3'd2:    wt_data = {16'd0, pd_q[15:0]};
			3'd3:    wt_data = {8'd0, pd_q[23:0]};
			default: wt_data = pd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == ST_IDLE);
		res_valid = 1'b0;
		res       = '0;
		tr_rd_set = la_set;
		tr_clr    = 1'b0;
		tr_we     = 1'b0;
		tr_wr_set = la_set;
		tr_wr_way = fill_way_q;
		tr_wr_tag = la_tag;
		dr_addr   = {la_set, gw_q, la_q[2 +: WRD_W]};
		dr_we     = 1'b0;
		dr_be     = 4'h0;
		dr_wdata  = {4{pd_q[8*gpos_q +: 8]}};
		case (state_q)
			ST_CLEAR: begin
				tr_clr    = 1'b1;
				tr_wr_set = clr_q;
				if (clr_q == SET_W'(SETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && in_op == OP_REFILL && mode_q != MODE_IDLE) begin
					dr_addr  = {la_set, fill_way_q, beat_q};
					dr_we    = 1'b1;
					dr_be    = 4'hF;
					dr_wdata = in_data;
					if (refill_last) begin
						tr_we   = 1'b1;
						state_d = ST_G_RD;
					end
				end else if (in_valid && mode_q == MODE_IDLE) begin
					if (in_op == OP_WRITE) begin
						state_d = ST_WR_TAG;
					end else if (in_op == OP_READ) begin
						state_d = ST_RD_TAG;
					end
				end
			end
			ST_WR_TAG: state_d = ST_WR_CMP;
			ST_WR_CMP: begin
				if (hit) begin
					dr_addr = {la_set, hit_way, la_q[2 +: WRD_W]};
					dr_we   = 1'b1;
					dr_be   = 4'b0001 << la_q[1:0];
				end
				state_d = (gn_q == 3'd1) ? ST_WR_DONE : ST_WR_TAG;
			end
			ST_WR_DONE: begin
				if (res_ready) begin
					res_valid = 1'b1;
					res.kind  = KIND_WRITE;
					res.addr  = p_addr_q;
					res.data  = wt_data;
					res.size  = p_size_q;
					state_d   = ST_IDLE;
				end
			end
			ST_RD_TAG: state_d = ST_RD_CMP;
			ST_RD_CMP: state_d = hit ? ST_G_RD : ST_FETCH;
			ST_FETCH: begin
				if (res_ready) begin
					res_valid = 1'b1;
					res.kind  = KIND_FETCH;
					res.addr  = {la_q[31:OFF_W], OFF_W'(0)};
					state_d   = ST_IDLE;
				end
			end
			ST_G_RD: state_d = ST_G_TAKE;
			ST_G_TAKE: begin
				if (gn_q == 3'd1) begin
					state_d = (!part_q && n2 != 3'd0) ? ST_RD_TAG : ST_FINISH;
				end else begin
					state_d = ST_G_RD;
				end
			end
			ST_FINISH: begin
				if (res_ready) begin
					res_valid = 1'b1;
					res.kind  = KIND_READ;
					res.addr  = p_addr_q;
					res.data  = acc_q;
					res.size  = p_size_q;
					res.hit   = all_hit_q;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			clr_q      <= '0;
			lfsr_q     <= SEED_RESET;
			beat_q     <= '0;
			fill_way_q <= '0;
			all_hit_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_valid && in_op == OP_REFILL && mode_q != MODE_IDLE) begin
						beat_q <= refill_last ? '0 : beat_q + 1'b1;
					end else if (in_valid && mode_q == MODE_IDLE && in_op == OP_READ) begin
						all_hit_q <= 1'b1;
					end
				end
				ST_RD_CMP: begin
					if (!hit) begin
						mode_q    <= part_q ? MODE_SECOND : MODE_FIRST;
						all_hit_q <= 1'b0;
					end
				end
				ST_FETCH: begin
					if (res_ready) begin
						fill_way_q <= inv_found ? inv_way : WAY_W'(lfsr_next % WAYS);
						if (!inv_found && !cfg_we) begin
							lfsr_q <= lfsr_next;
						end
						beat_q <= '0;
					end
				end
				ST_FINISH: begin
					if (res_ready) begin
						mode_q <= MODE_IDLE;
					end
				end
				default: ;
			endcase
			if (cfg_we) begin
				lfsr_q <= cfg_seed;
			end
		end
	end

	// access payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_REFILL && mode_q != MODE_IDLE) begin
					if (refill_last) begin
						gw_q   <= fill_way_q;
						gn_q   <= (mode_q == MODE_FIRST) ? n1_q : n2;
						gpos_q <= (mode_q == MODE_FIRST) ? 2'd0 : n1_q[1:0];
						part_q <= (mode_q == MODE_SECOND);
					end
				end else if (in_valid && mode_q == MODE_IDLE) begin
					p_addr_q <= in_addr;
					p_size_q <= sz;
					pd_q     <= in_data;
					la_q     <= in_addr;
					n1_q     <= n1_in;
					gn_q     <= sz;
					gpos_q   <= 2'd0;
					acc_q    <= '0;
					part_q   <= 1'b0;
				end
			end
			ST_WR_CMP: begin
				la_q   <= la_q + 32'd1;
				gn_q   <= gn_q - 3'd1;
				gpos_q <= gpos_q + 2'd1;
			end
			ST_RD_CMP: begin
				if (hit) begin
					gw_q   <= hit_way;
					gn_q   <= part_q ? n2 : n1_q;
					gpos_q <= part_q ? n1_q[1:0] : 2'd0;
				end
			end
			ST_G_TAKE: begin
				acc_q[8*gpos_q +: 8] <= rd_byte;
				la_q   <= la_q + 32'd1;
				gn_q   <= gn_q - 3'd1;
				gpos_q <= gpos_q + 2'd1;
				if (gn_q == 3'd1) begin
					part_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/sac_checker.sv
`timescale 1ns / 1ps
module sac_checker #(
	parameter int LINE_BYTES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import sac_pkg::*;

	localparam int OFF_W = $clog2(LINE_BYTES);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("unknown result kind");

	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_FETCH |->
		m_axis_tdata[OFF_W-1:0] == '0 && m_axis_tdata[67:32] == '0)
		else $error("line fetch not line aligned or carries data");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_FETCH |->
		m_axis_tdata[66:64] != 3'd0 && m_axis_tdata[66:64] <= 3'd4)
		else $error("byte count out of range");

	a_wt_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_WRITE |-> !m_axis_tdata[67])
		else $error("write-through flagged as hit");

endmodule

bind set_assoc_write_through_cache_unit sac_checker #(
	.LINE_BYTES(LINE_BYTES)
) u_sac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/sv/cache_checker.sv
`timescale 1ns / 1ps
module cache_checker
	import sac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [1:0]           s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]           m_axis_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [SEED_W-1:0]    cfg_data,
	output int                   errors,
	output int                   outstanding
);

	// shadow copy of the cache
	bit              line_valid [1024];
	bit [18:0]       line_tag   [1024];
	bit [31:0]       line_word  [16384];
	bit [SEED_W-1:0] lfsr;
	mode_t           mode;
	bit [31:0]       req_addr;
	bit [2:0]        req_size;
	int              beat_no;
	int              fill_way;
	bit [31:0]       first_bytes;
	bit              all_hit;

	res_t            pending_results [$];

	assign outstanding = pending_results.size();

	function automatic void push_result(kind_t k, bit [31:0] a, bit [31:0] d, bit [2:0] n,
			bit h);
		res_t r;
		r.kind = k;
		r.addr = a;
		r.data = d;
		r.size = n;
		r.hit  = h;
		pending_results.push_back(r);
	endfunction

	function automatic bit find_line(bit [31:0] a, output int slot);
		int base;
		base = int'(a[12:6]) * 8;
		slot = 0;
		for (int w = 0; w < 8; w++) begin
			if (line_valid[base + w] && line_tag[base + w] == a[31:13]) begin
				slot = base + w;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit [31:0] read_bytes(bit [31:0] a, int n);
		int slot;
		int off;
		bit [31:0] v;
		bit [31:0] w;
		v = 0;
		if (!find_line(a, slot))
			return 0;
		for (int i = 0; i < n; i++) begin
			off = int'(a[5:0]) + i;
			w = line_word[slot * 16 + (off / 4) % 16];
			v |= ((w >> (8 * (off % 4))) & 32'hff) << (8 * i);
		end
		return v;
	endfunction

	function automatic int bytes_in_line(bit [31:0] a, bit [2:0] n);
		int room;
		room = 64 - int'(a[5:0]);
		return (int'(n) < room) ? int'(n) : room;
	endfunction

	function automatic void start_fetch(bit [31:0] a);
		int base;
		int w;
		bit lsb;
		base = int'(a[12:6]) * 8;
		for (w = 0; w < 8; w++)
			if (!line_valid[base + w])
				break;
		if (w == 8) begin
			lsb = lfsr[0];
			lfsr = lfsr >> 1;
			if (lsb)
				lfsr ^= LFSR_TAPS;
			w = int'(lfsr[2:0]);
		end
		fill_way = w;
		beat_no = 0;
		push_result(KIND_FETCH, {a[31:6], 6'b0}, 0, 0, 0);
	endfunction

	function automatic void answer_read();
		int n1;
		int n2;
		bit [31:0] v;
		n1 = bytes_in_line(req_addr, req_size);
		n2 = int'(req_size) - n1;
		v = first_bytes;
		if (n2 != 0)
			v |= read_bytes(req_addr + n1, n2) << (8 * n1);
		mode = MODE_IDLE;
		push_result(KIND_READ, req_addr, v, req_size, all_hit);
	endfunction

	function automatic void first_part_ready();
		int n1;
		int slot;
		n1 = bytes_in_line(req_addr, req_size);
		first_bytes = read_bytes(req_addr, n1);
		if (int'(req_size) > n1 && !find_line(req_addr + n1, slot)) begin
			mode = MODE_SECOND;
			all_hit = 0;
			start_fetch(req_addr + n1);
		end else begin
			answer_read();
		end
	endfunction

	function automatic void take_beat(op_t op, bit [31:0] a, bit [2:0] n, bit [31:0] d);
		bit [31:0] la;
		int slot;
		int sh;
		if (n == 0)
			n = 1;
		if (n > 4)
			n = 4;
		if (op == OP_REFILL) begin
			if (mode == MODE_IDLE)
				return;
			la = req_addr;
			if (mode == MODE_SECOND)
				la = req_addr + bytes_in_line(req_addr, req_size);
			slot = int'(la[12:6]) * 8 + fill_way;
			line_word[slot * 16 + beat_no] = d;
			if (beat_no < 15) begin
				beat_no++;
				return;
			end
			beat_no = 0;
			line_valid[slot] = 1;
			line_tag[slot] = la[31:13];
			if (mode == MODE_FIRST)
				first_part_ready();
			else
				answer_read();
			return;
		end
		if (op == OP_NONE || mode != MODE_IDLE)
			return;
		if (op == OP_WRITE) begin
			for (int i = 0; i < int'(n); i++) begin
				la = a + i;
				if (find_line(la, slot)) begin
					sh = 8 * int'(la[1:0]);
					slot = slot * 16 + int'(la[5:2]);
					line_word[slot] = (line_word[slot] & ~(32'hff << sh))
						| (((d >> (8 * i)) & 32'hff) << sh);
				end
			end
			push_result(KIND_WRITE, a, (n == 4) ? d : (d & ((32'd1 << (8 * n)) - 1)), n, 0);
			return;
		end
		req_addr = a;
		req_size = n;
		all_hit = 1;
		first_bytes = 0;
		if (find_line(a, slot)) begin
			first_part_ready();
		end else begin
			mode = MODE_FIRST;
			all_hit = 0;
			start_fetch(a);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			foreach (line_valid[i])
				line_valid[i] = 0;
			lfsr = SEED_RESET;
			mode = MODE_IDLE;
			req_addr = 0;
			req_size = 0;
			beat_no = 0;
			fill_way = 0;
			first_bytes = 0;
			all_hit = 1;
			errors = 0;
			pending_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = kind_t'(m_axis_tuser);
				got.addr = m_axis_tdata[31:0];
				got.data = m_axis_tdata[63:32];
				got.size = m_axis_tdata[66:64];
				got.hit  = m_axis_tdata[67];
				if (pending_results.size() == 0) begin
					errors++;
					$display("%t: unexpected result beat, got %p", $time, got);
				end else begin
					want = pending_results.pop_front();
					if (got.kind != want.kind || got.addr != want.addr
							|| got.data != want.data || got.size != want.size
							|| got.hit != want.hit) begin
						errors++;
						$display("%t: mismatch, expected %p, actual %p", $time, want, got);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				lfsr = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				take_beat(op_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[34:32],
					s_axis_tdata[66:35]);
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sac_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 235;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_axis_tvalid = 0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = OP_NONE;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [SEED_W-1:0]    cfg_data = '0;

	int errors;
	int outstanding;

	// handshake bookkeeping shared with the stimulus process
	int reads_sent;
	int reads_done;
	int fetches_seen;
	int refills_sent;
	int items_sent;
	int burst_left;
	int idle_cycles = 0;

	// small tag pool so that sets fill up and victims get picked
	bit [18:0] tag_pool [12];

	always #5 clk = ~clk;

	set_assoc_write_through_cache_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	cache_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	// result side: count read answers and line fetches so the sender knows when
	// to supply refill beats and when a read is over
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_done <= 0;
			fetches_seen <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (m_axis_tuser == KIND_READ)
				reads_done <= reads_done + 1;
			if (m_axis_tuser == KIND_FETCH)
				fetches_seen <= fetches_seen + 1;
		end
	end

	// receiver back-pressure: a mode picked at random from always ready,
	// coin toss, or a rotating 8-bit pattern
	int       stall_mode;
	int       stall_cnt;
	bit [7:0] stall_pat;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			stall_mode <= 0;
			stall_cnt <= 0;
			stall_pat <= 8'hff;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 128 == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_pat <= 8'($urandom) | 8'h01;
			end else begin
				stall_pat <= {stall_pat[6:0], stall_pat[7]};
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= stall_pat[0];
			endcase
		end
	end

	// watchdog: cycles without any beat on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** set_assoc_write_through_cache_unit: FAILED **");
			$finish;
		end
	end

	// Offer one beat; returns at the edge where it is taken. The caller must then
	// either offer the next beat or call drop_valid in the same step.
	task automatic send(op_t op, logic [31:0] a, logic [2:0] sz, logic [31:0] d);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'b0, d, sz, a};
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drop_valid();
		s_axis_tvalid <= 1'b0;
	endtask

	// feed refill beats for every fetch until the read answer comes back,
	// now and then slipping in an access that the busy cache must drop
	task automatic complete_read();
		int fetches;
		int k;
		drop_valid();
		forever begin
			@(negedge clk);
			if (reads_done == reads_sent)
				break;
			fetches = fetches_seen;
			if (fetches * 16 > refills_sent) begin
				@(posedge clk);
				while (refills_sent < fetches * 16) begin
					if ($urandom_range(0, 24) == 0) begin
						k = $urandom_range(0, 2);
						send(k == 2 ? OP_NONE : op_t'(k), $urandom,
							3'($urandom_range(0, 7)), $urandom);
					end
					send(OP_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom);
					refills_sent++;
					items_sent++;
				end
				drop_valid();
			end
		end
		@(posedge clk);
	endtask

	task automatic access(op_t op, logic [31:0] a, logic [2:0] sz, logic [31:0] d);
		send(op, a, sz, d);
		items_sent++;
		if (op == OP_READ) begin
			reads_sent++;
			complete_read();
		end
	endtask

	task automatic settle();
		drop_valid();
		@(negedge clk);
		while (outstanding != 0 || reads_done != reads_sent)
			@(negedge clk);
		// all expected results are in; let the bus idle before the next phase
		repeat (40) @(posedge clk);
	endtask

	task automatic write_seed(logic [SEED_W-1:0] seed);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_addr();
		logic [6:0] set_idx;
		logic [5:0] off;
		if ($urandom_range(0, 19) == 0)
			return $urandom;
		set_idx = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
		off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom);
		return {tag_pool[$urandom_range(0, 11)], set_idx, off};
	endfunction

	task automatic random_phase();
		int n;
		int pick;
		n = items_sent + PHASE_ITEMS;
		while (items_sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				access(OP_READ, pick_addr(), 3'($urandom_range(0, 7)), $urandom);
			else if (pick < 92)
				access(OP_WRITE, pick_addr(), 3'($urandom_range(0, 7)), $urandom);
			else
				// stray refill or unused opcode, both ignored while idle
				send(pick < 96 ? OP_REFILL : OP_NONE, $urandom, 3'($urandom_range(0, 7)),
					$urandom);
		end
	endtask

	initial begin
		reads_sent = 0;
		refills_sent = 0;
		items_sent = 0;
		burst_left = 0;
		foreach (tag_pool[i])
			tag_pool[i] = 19'($urandom);
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: miss then hit, write hit, size wrap-around codes, line and
		// address-space crossings, ignored beats, and a full set forcing victims
		access(OP_READ, 32'h0000_0000, 3'd1, 32'h0);
		access(OP_READ, 32'h0000_0000, 3'd4, 32'h0);
		access(OP_WRITE, 32'h0000_0000, 3'd4, 32'hffff_ffff);
		access(OP_READ, 32'h0000_0000, 3'd4, 32'h0);
		access(OP_WRITE, 32'h0000_003e, 3'd0, 32'h0000_0000);
		access(OP_READ, 32'h0000_003e, 3'd4, 32'h0);
		access(OP_READ, 32'hffff_fffe, 3'd7, 32'h0);
		access(OP_WRITE, 32'hffff_ffff, 3'd5, 32'ha5a5_a5a5);
		access(OP_READ, 32'hffff_fffc, 3'd4, 32'hffff_ffff);
		send(OP_NONE, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
		send(OP_REFILL, 32'h0, 3'd2, 32'h1234_5678);
		for (int t = 1; t <= 9; t++)
			access(OP_READ, 32'(t) << 13, 3'd3, 32'h0);
		access(OP_WRITE, 32'h0000_6000, 3'd2, 32'h5a5a_5a5a);
		access(OP_READ, 32'h0000_6000, 3'd4, 32'h0);
		settle();

		// seed phases, the extremes and zero among them
		write_seed(16'd1);
		random_phase();
		settle();
		write_seed(16'hffff);
		random_phase();
		settle();
		write_seed(16'd0);
		random_phase();
		settle();
		write_seed(16'($urandom_range(1, 65535)));
		random_phase();
		settle();
		write_seed(SEED_RESET);
		random_phase();
		settle();

		if (errors == 0)
			$display("** set_assoc_write_through_cache_unit: PASSED **");
		else
			$display("** set_assoc_write_through_cache_unit: FAILED **");
		$finish;
	end

endmodule
